### rtl/core/bc1d_pkg.sv
package bc1d_pkg;

	// texels in one 4x4 block
	localparam int TEXELS = 16;
	localparam int TEXEL_NUM_W = $clog2(TEXELS);
	localparam logic [TEXEL_NUM_W-1:0] TEXEL_LAST = TEXEL_NUM_W'(TEXELS - 1);

	// field positions in the compressed block word
	localparam int BLOCK_W = 64;
	localparam int INDEX_W = 2 * TEXELS;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	// expanded endpoints plus palette mode and texel indices
	typedef struct packed {
		rgb_t               e0;
		rgb_t               e1;
		logic               four;
		logic [INDEX_W-1:0] idx;
	} endp_t;

	// full four-entry palette plus texel indices
	typedef struct packed {
		rgb_t [3:0]         entry;
		logic [INDEX_W-1:0] idx;
	} pal_t;

	typedef struct packed {
		logic                   last;
		logic [TEXEL_NUM_W-1:0] texel_number;
		rgb_t                   color;
	} texel_t;

endpackage

### rtl/core/bc1d_endpoint_expand.sv
module bc1d_endpoint_expand (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      force_four_color,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [bc1d_pkg::BLOCK_W-1:0] in_block,
	output logic                      out_valid,
	input  logic                      out_ready,
	output bc1d_pkg::endp_t           out_endp
);
	import bc1d_pkg::*;

	logic           valid_s1;
	endp_t          endp_s1;
	logic [15:0]    c0;
	logic [15:0]    c1;

	// v*255/31 == 8v + floor(7v/31)
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [7:0] t;
		logic [2:0] f;
		t = ({3'b000, v} << 3) - {3'b000, v};
		f = 3'(t >= 8'd31) + 3'(t >= 8'd62) + 3'(t >= 8'd93) + 3'(t >= 8'd124)
			+ 3'(t >= 8'd155) + 3'(t >= 8'd186) + 3'(t >= 8'd217);
		return {v, 3'b000} + {5'b00000, f};
	endfunction

	// v*255/63 == 4v + floor(v/21)
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [1:0] f;
		f = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
		return {v, 2'b00} + {6'b000000, f};
	endfunction

	function automatic rgb_t expand565(input logic [15:0] c);
		rgb_t p;
		p.red   = expand5(c[15:11]);
		p.green = expand6(c[10:5]);
		p.blue  = expand5(c[4:0]);
		return p;
	endfunction

	assign c0       = in_block[15:0];
	assign c1       = in_block[31:16];
	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			endp_s1.e0   <= expand565(c0);
			endp_s1.e1   <= expand565(c1);
			endp_s1.four <= force_four_color || (c0 > c1);
			endp_s1.idx  <= in_block[BLOCK_W-1:32];
		end
	end

	assign out_valid = valid_s1;
	assign out_endp  = endp_s1;

endmodule

### rtl/core/bc1d_palette.sv
module bc1d_palette (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bc1d_pkg::endp_t in_endp,
	output logic            out_valid,
	input  logic            out_ready,
	output bc1d_pkg::pal_t  out_pal
);
	import bc1d_pkg::*;

	logic valid_s2;
	pal_t pal_s2;
	rgb_t mix2;
	rgb_t mix3;

	// floor(x/3) for x below 768
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'd683;
		return p[18:11];
	endfunction

	// entries 2 and 3 of one channel, entry 2 in the low byte
	function automatic logic [15:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
		input logic four);
		logic [9:0] s2;
		logic [9:0] s3;
		logic [8:0] avg;
		s2  = {1'b0, a, 1'b0} + {2'b00, b};
		s3  = {2'b00, a} + {1'b0, b, 1'b0};
		avg = {1'b0, a} + {1'b0, b};
		if (four) begin
			return {div3(s3), div3(s2)};
		end
		// three-color mode: average and black
		return {8'h00, avg[8:1]};
	endfunction

	always_comb begin
		{mix3.red, mix2.red}     = mix_channel(in_endp.e0.red, in_endp.e1.red, in_endp.four);
		{mix3.green, mix2.green} = mix_channel(in_endp.e0.green, in_endp.e1.green,
			in_endp.four);
		{mix3.blue, mix2.blue}   = mix_channel(in_endp.e0.blue, in_endp.e1.blue, in_endp.four);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pal_s2.entry[0] <= in_endp.e0;
			pal_s2.entry[1] <= in_endp.e1;
			pal_s2.entry[2] <= mix2;
			pal_s2.entry[3] <= mix3;
			pal_s2.idx      <= in_endp.idx;
		end
	end

	assign out_valid = valid_s2;
	assign out_pal   = pal_s2;

endmodule

### rtl/core/bc1d_texel_serializer.sv
module bc1d_texel_serializer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bc1d_pkg::pal_t   in_pal,
	output logic             out_valid,
	input  logic             out_ready,
	output bc1d_pkg::texel_t out_texel
);
	import bc1d_pkg::*;

	logic                   valid_s3;
	pal_t                   pal_s3;
	logic [TEXEL_NUM_W-1:0] cnt_q;
	logic                   out_valid_q;
	texel_t                 texel_q;
	logic                   out_load;
	logic [1:0]             sel;

	// output register takes a texel whenever s3 holds a palette and the register is empty or being drained
	assign out_load = valid_s3 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s3 || (out_load && (cnt_q == TEXEL_LAST));
	assign sel      = pal_s3.idx[{cnt_q, 1'b0} +: 2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (out_load) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pal_s3 <= in_pal;
		end
		if (out_load) begin
			texel_q.color        <= pal_s3.entry[sel];
			texel_q.texel_number <= cnt_q;
			texel_q.last         <= (cnt_q == TEXEL_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_texel = texel_q;

endmodule

### rtl/core/bc1_color_block_decoder_top.sv
// bc1 color block decoder
//
// s_axis takes one 8-byte compressed color block per transaction as a
// little-endian 64-bit word: color0 in bits 15:0, color1 in bits 31:16 and
// sixteen 2-bit texel indices above. m_axis gives the sixteen decoded texels
// of each block in row-major order, one texel per transaction, with tlast on
// the sixteenth.
// cfg is a write-only channel for force_four_color, always ready; write it
// only while no block is in flight.
// pipeline: s1 expands both rgb565 endpoints and picks the palette mode,
// s2 builds the four-entry palette, s3 holds the palette and steps through
// the indices into the output register.
// throughput: one texel per cycle while m_axis_tready is high; the s3 texel
// counter steps through the sixteen indices of a block. up to two more blocks
// wait in s1 and s2 while a block is being emitted from s3.
// reset clears all valid bits and the texel counter and sets
// force_four_color to 0. when m_axis_tready is low the output register holds
// its texel and the stall backs up stage by stage to s_axis_tready; nothing
// is dropped or repeated.
module bc1_color_block_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	// block input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // block_word
	// texel output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // red, green, blue, texel_number, zero pad
	output logic        m_axis_tlast,  // last
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data       // force_four_color
);
	import bc1d_pkg::*;

	logic   force_q;
	logic   endp_valid;
	logic   endp_ready;
	endp_t  endp;
	logic   pal_valid;
	logic   pal_ready;
	pal_t   pal;
	texel_t texel;
	logic [TEXEL_NUM_W-1:0] exp_num_q;

	// register write is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			force_q <= cfg_data;
		end
	end

	// s1: endpoint expansion and palette mode
	bc1d_endpoint_expand u_expand (
		.clk              (clk),
		.arst_n           (arst_n),
		.force_four_color (force_q),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.in_block         (s_axis_tdata),
		.out_valid        (endp_valid),
		.out_ready        (endp_ready),
		.out_endp         (endp)
	);

	// s2: interpolated palette entries
	bc1d_palette u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (endp_valid),
		.in_ready  (endp_ready),
		.in_endp   (endp),
		.out_valid (pal_valid),
		.out_ready (pal_ready),
		.out_pal   (pal)
	);

	// s3: texel stepping and output register
	bc1d_texel_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pal_valid),
		.in_ready  (pal_ready),
		.in_pal    (pal),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_texel (texel)
	);

	assign m_axis_tdata = {4'b0000, texel.texel_number, texel.color.blue, texel.color.green,
		texel.color.red};
	assign m_axis_tlast = texel.last;

	// texel number the next output transaction must carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_num_q <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			exp_num_q <= exp_num_q + 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_tlast_on_final_texel: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (texel.texel_number == TEXEL_LAST)))
		else $error("tlast does not match the final texel");

	a_texel_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (texel.texel_number == exp_num_q))
		else $error("texel emitted out of order");

	a_no_accept_mid_block: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && pal_valid && !m_axis_tlast) |-> !pal_ready)
		else $error("serializer took a new palette while stalled mid-block");
`endif

endmodule
